>>> src/lcdseq_pkg.sv
package lcdseq_pkg;

   // Request codes carried in the cmd field.
   localparam logic [2:0] CMD_INIT        = 3'd0;
   localparam logic [2:0] CMD_PUT_CHAR    = 3'd1;
   localparam logic [2:0] CMD_SET_CURSOR  = 3'd2;
   localparam logic [2:0] CMD_CLEAR       = 3'd3;
   localparam logic [2:0] CMD_BRIGHTNESS  = 3'd4;
   localparam logic [2:0] CMD_DEFINE_GLYPH = 3'd5;
   localparam logic [2:0] CMD_PRINT_BEGIN = 3'd6;

   // Controller instruction bytes.
   localparam logic [7:0] INSTR_FUNCTION_SET = 8'h38;
   localparam logic [7:0] INSTR_DISPLAY_ON   = 8'h0C;
   localparam logic [7:0] INSTR_CLEAR        = 8'h01;
   localparam logic [7:0] INSTR_SET_DDRAM    = 8'h80;
   localparam logic [7:0] INSTR_SET_CGRAM    = 8'h40;

   // Register-select values.
   localparam logic RS_INSTR = 1'b0;
   localparam logic RS_DATA  = 1'b1;

   localparam int CURSOR_COL_W = 6;
   localparam int QUEUE_DEPTH  = 2;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [7:0]  char_code;
      logic [7:0]  col;
      logic [7:0]  row;
      logic [1:0]  level;
      logic [2:0]  glyph_id;
      logic [63:0] glyph_rows;
   } lcdseq_req_type;

   typedef struct packed {
      logic       reg_select;
      logic [7:0] bus_byte;
      logic       last;
   } lcdseq_rsp_type;

   typedef enum logic [2:0] {
      JOB_INIT,
      JOB_PUT,
      JOB_PUT_WRAP,
      JOB_ADDR,
      JOB_CLEAR,
      JOB_BRIGHT,
      JOB_GLYPH
   } lcdseq_job_op_type;

   // One classified request as handed from the front end to the sequencer.
   typedef struct packed {
      lcdseq_job_op_type op;
      logic [7:0]        data;
      logic [7:0]        addr;
      logic [1:0]        level;
      logic [63:0]       rows;
   } lcdseq_job_type;

   // Handshake between a producer and the job queue.
   typedef struct packed {
      logic push;
      logic full;
   } lcdseq_qin_type;

endpackage

>>> src/lcdseq_front.sv
module lcdseq_front
   import lcdseq_pkg::*;
#(
   parameter int COLUMNS = 16,
   parameter int ROWS    = 2
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_push,
   output logic           req_full,
   input  lcdseq_req_type req_data,
   input  logic           queue_full,
   output logic           job_push,
   output lcdseq_job_type job_data
);

   localparam logic [13:0] COLS_WIDE = 14'(COLUMNS);
   localparam logic [CURSOR_COL_W:0] COLS_CMP = (CURSOR_COL_W + 1)'(COLUMNS);
   localparam logic [7:0] BRIGHT_ADDR = INSTR_SET_DDRAM | 8'(COLUMNS & 'h7F);

   logic [CURSOR_COL_W-1:0] cursor_col_ff, cursor_col_in;
   logic                    cursor_row_ff, cursor_row_in;

   logic [13:0]             col_rem;
   logic [CURSOR_COL_W:0]   col_inc;
   logic                    cmd_valid;
   logic                    accept;

   // Reduce the requested column by shift-and-subtract, one compare per bit.
   always_comb begin
      col_rem = {6'd0, req_data.col};
      for (int k = 7; k >= 0; k--) begin
         if (col_rem >= (COLS_WIDE << k)) begin
            col_rem = col_rem - (COLS_WIDE << k);
         end
      end
   end

   assign col_inc  = {1'b0, cursor_col_ff} + 1'b1;
   assign req_full = queue_full;
   assign accept   = req_push && !queue_full;

   always_comb begin
      cmd_valid     = 1'b1;
      cursor_col_in = cursor_col_ff;
      cursor_row_in = cursor_row_ff;
      job_data.op    = JOB_CLEAR;
      job_data.data  = req_data.char_code;
      job_data.level = req_data.level;
      job_data.rows  = req_data.glyph_rows;
      case (req_data.cmd)
         CMD_INIT: begin
            job_data.op   = JOB_INIT;
            cursor_col_in = '0;
            cursor_row_in = 1'b0;
         end
         CMD_PUT_CHAR: begin
            if (col_inc >= COLS_CMP) begin
               job_data.op   = JOB_PUT_WRAP;
               cursor_col_in = '0;
               cursor_row_in = (ROWS == 2) ? ~cursor_row_ff : 1'b0;
            end else begin
               job_data.op   = JOB_PUT;
               cursor_col_in = col_inc[CURSOR_COL_W-1:0];
            end
         end
         CMD_SET_CURSOR: begin
            job_data.op   = JOB_ADDR;
            cursor_col_in = col_rem[CURSOR_COL_W-1:0];
            cursor_row_in = (ROWS == 2) ? req_data.row[0] : 1'b0;
         end
         CMD_CLEAR: begin
            job_data.op = JOB_CLEAR;
         end
         CMD_BRIGHTNESS: begin
            job_data.op   = JOB_BRIGHT;
            job_data.data = BRIGHT_ADDR;
         end
         CMD_DEFINE_GLYPH: begin
            job_data.op   = JOB_GLYPH;
            job_data.data = INSTR_SET_CGRAM | {2'b00, req_data.glyph_id, 3'b000};
         end
         CMD_PRINT_BEGIN: begin
            job_data.op = JOB_ADDR;
         end
         default: begin
            cmd_valid = 1'b0;
         end
      endcase
      // The address write always shows the cursor as it stands after the request.
      job_data.addr = INSTR_SET_DDRAM | {1'b0, cursor_row_in, cursor_col_in};
   end

   assign job_push = accept && cmd_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_col_ff <= '0;
         cursor_row_ff <= 1'b0;
      end else if (job_push) begin
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
      end
   end

endmodule

>>> src/lcdseq_queue.sv
module lcdseq_queue
   import lcdseq_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  lcdseq_job_type push_data,
   output lcdseq_qin_type in_ctrl,
   input  logic           push,
   input  logic           pop,
   output logic           empty,
   output lcdseq_job_type head
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   lcdseq_job_type slots_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign in_ctrl.push = push;
   assign in_ctrl.full = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty        = (count_ff == '0);
   assign do_push      = push && !in_ctrl.full;
   assign do_pop       = pop && !empty;
   assign head         = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> src/lcdseq_back.sv
module lcdseq_back
   import lcdseq_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           job_empty,
   input  lcdseq_job_type job,
   output logic           job_pop,
   output logic           rsp_empty,
   input  logic           rsp_pop,
   output lcdseq_rsp_type rsp_data
);

   logic [3:0]     step_ff, step_in;
   logic           out_valid_ff, out_valid_in;
   lcdseq_rsp_type out_ff, out_in;

   logic [3:0]     final_step;
   logic [2:0]     row_sel;
   logic           advance;
   logic           is_last;
   logic [3:0]     step_less;

   assign advance   = !job_empty && (!out_valid_ff || rsp_pop);
   assign is_last   = (step_ff == final_step);
   assign step_less = step_ff - 4'd1;
   assign row_sel   = step_less[2:0];
   assign job_pop   = advance && is_last;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      final_step        = 4'd0;
      out_in.reg_select = RS_INSTR;
      out_in.bus_byte   = job.addr;
      case (job.op)
         JOB_INIT: begin
            final_step = 4'd2;
            case (step_ff)
               4'd0:    out_in.bus_byte = INSTR_FUNCTION_SET;
               4'd1:    out_in.bus_byte = INSTR_DISPLAY_ON;
               default: out_in.bus_byte = INSTR_CLEAR;
            endcase
         end
         JOB_PUT, JOB_PUT_WRAP: begin
            final_step = (job.op == JOB_PUT_WRAP) ? 4'd1 : 4'd0;
            if (step_ff == 4'd0) begin
               out_in.reg_select = RS_DATA;
               out_in.bus_byte   = job.data;
            end
         end
         JOB_ADDR: begin
            final_step = 4'd0;
         end
         JOB_CLEAR: begin
            final_step      = 4'd0;
            out_in.bus_byte = INSTR_CLEAR;
         end
         JOB_BRIGHT: begin
            final_step = 4'd3;
            case (step_ff)
               4'd0:    out_in.bus_byte = job.data;
               4'd1:    out_in.bus_byte = INSTR_FUNCTION_SET | {6'd0, job.level};
               4'd2: begin
                  out_in.reg_select = RS_DATA;
                  out_in.bus_byte   = {6'd0, job.level};
               end
               default: out_in.bus_byte = job.addr;
            endcase
         end
         JOB_GLYPH: begin
            final_step = 4'd8;
            if (step_ff == 4'd0) begin
               out_in.bus_byte = job.data;
            end else begin
               out_in.reg_select = RS_DATA;
               out_in.bus_byte   = job.rows[{row_sel, 3'b000} +: 8];
            end
         end
         default: begin
            final_step = 4'd0;
         end
      endcase
      out_in.last = is_last;
   end

   always_comb begin
      step_in      = step_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      if (advance) begin
         out_valid_in = 1'b1;
         step_in      = is_last ? 4'd0 : step_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= 4'd0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

endmodule

>>> src/char_lcd_command_sequencer_top.sv
// Character display command sequencer. Each accepted request becomes a fixed run of
// controller bus writes (register-select bit, byte, and a last flag on the final write
// of the request), delivered in order through a queue-style result port. The block
// keeps the cursor column and row itself, so put character advances and wraps the
// cursor and set cursor, brightness and print-begin can send the right address.
// Requests are accepted one per cycle while the two-entry job queue has room; the
// back-end sequencer then issues one bus write per cycle while results are popped.
// A request has one write for put character, set cursor, clear and print-begin,
// two for a put character that wraps, three for init, four for brightness and nine
// for define glyph. The sequencer's write rate sets the sustained rate.
// Unused command codes are dropped at the front and produce no writes.
module char_lcd_command_sequencer_top
   import lcdseq_pkg::*;
#(
   parameter int COLUMNS = 16,
   parameter int ROWS    = 2
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_push,
   output logic           req_full,
   input  lcdseq_req_type req_data,
   output logic           rsp_empty,
   input  logic           rsp_pop,
   output lcdseq_rsp_type rsp_data
);

   // Jobs flow from the front end through the queue into the sequencer.
   lcdseq_job_type front_job;
   lcdseq_job_type head_job;
   lcdseq_qin_type queue_ctrl;
   logic           front_push;
   logic           queue_empty;
   logic           back_pop;

   // The front end classifies each request and tracks the cursor.
   lcdseq_front #(
      .COLUMNS(COLUMNS),
      .ROWS   (ROWS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .queue_full(queue_ctrl.full),
      .job_push  (front_push),
      .job_data  (front_job)
   );

   // The short queue lets the front end keep accepting while writes drain.
   lcdseq_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_data(front_job),
      .in_ctrl  (queue_ctrl),
      .push     (front_push),
      .pop      (back_pop),
      .empty    (queue_empty),
      .head     (head_job)
   );

   // The sequencer expands one job into its bus writes behind an output register.
   lcdseq_back u_back (
      .clock    (clock),
      .reset    (reset),
      .job_empty(queue_empty),
      .job      (head_job),
      .job_pop  (back_pop),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_data (rsp_data)
   );

endmodule

>>> tb/tb_char_lcd_command_sequencer_top.sv
`timescale 1ns / 1ps

// Testbench for the character display command sequencer.
//
// Requests are driven on the push/full side at the falling clock edge, and both
// handshakes are observed at the rising edge by a single monitor. The monitor
// first turns every accepted request into the bus writes it should produce and
// then checks every accepted bus write against the oldest pending one. A short
// directed pass walks the extremes and every request kind. A long random pass
// follows, built mostly from lines of text so that the cursor wraps often.
module tb_char_lcd_command_sequencer_top;
   import lcdseq_pkg::*;

   localparam int COLUMNS = 16;
   localparam int ROWS    = 2;

   // Code 7 has no meaning to the block; such requests must vanish.
   localparam logic [2:0] CMD_UNUSED = 3'd7;

   localparam int RANDOM_REQUESTS = 500;
   // Longest quiet stretch of a correct run is a sender gap or a receiver
   // stall, so this leaves a wide margin.
   localparam int IDLE_LIMIT      = 3000;
   // After the last write arrives we linger long enough to catch any stray
   // write from a nine-write request still in flight.
   localparam int DRAIN_CYCLES    = 24;

   // A request together with an optional typed expectation. When pinned is
   // set, the request must produce exactly the single write in typed_write.
   typedef struct {
      lcdseq_req_type req;
      bit             pinned;
      lcdseq_rsp_type typed_write;
   } request_plan_t;

   logic           clock;
   logic           reset;
   logic           req_push;
   logic           req_full;
   lcdseq_req_type req_data;
   logic           rsp_empty;
   logic           rsp_pop = 1'b0;
   lcdseq_rsp_type rsp_data;

   // Cursor as the display should have it after every accepted request.
   logic [5:0] disp_col;
   logic       disp_row;

   // Bus writes still owed by the block, oldest first.
   lcdseq_rsp_type expected_writes[$];
   // Plans of requests that are driven but not yet accepted, oldest first.
   request_plan_t  pending_plans[$];
   request_plan_t  directed_rows[$];

   int write_mismatches = 0;
   int writes_checked   = 0;
   int cursor_wraps     = 0;
   int glyphs_defined   = 0;
   int requests_taken   = 0;
   int ignored_taken    = 0;
   int idle_cycles      = 0;

   // Sender burst state: requests left in the current burst.
   int  burst_left = 4;
   // Set once all requests are in, so the receiver stops stalling.
   bit  draining = 1'b0;

   char_lcd_command_sequencer_top #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Works out the bus writes that one request produces and moves the cursor
   // the way the display would. Unused codes yield no writes at all.
   function automatic void forecast_bus_writes(input lcdseq_req_type r,
                                               output lcdseq_rsp_type writes[$]);
      logic [7:0] ddram_addr;
      writes.delete();
      case (r.cmd)
         CMD_INIT: begin
            writes.push_back('{RS_INSTR, INSTR_FUNCTION_SET, 1'b0});
            writes.push_back('{RS_INSTR, INSTR_DISPLAY_ON, 1'b0});
            writes.push_back('{RS_INSTR, INSTR_CLEAR, 1'b0});
            disp_col = '0;
            disp_row = 1'b0;
         end
         CMD_PUT_CHAR: begin
            writes.push_back('{RS_DATA, r.char_code, 1'b0});
            if (int'(disp_col) + 1 >= COLUMNS) begin
               // Past the last column the cursor drops to the start of the
               // next row, and the display has to be told the new address.
               disp_col = '0;
               disp_row = 1'((int'(disp_row) + 1) % ROWS);
               cursor_wraps++;
               ddram_addr = INSTR_SET_DDRAM | {1'b0, disp_row, disp_col};
               writes.push_back('{RS_INSTR, ddram_addr, 1'b0});
            end else begin
               disp_col = disp_col + 6'd1;
            end
         end
         CMD_SET_CURSOR: begin
            disp_col = 6'(int'(r.col) % COLUMNS);
            disp_row = 1'(int'(r.row) % ROWS);
            ddram_addr = INSTR_SET_DDRAM | {1'b0, disp_row, disp_col};
            writes.push_back('{RS_INSTR, ddram_addr, 1'b0});
         end
         CMD_CLEAR: begin
            writes.push_back('{RS_INSTR, INSTR_CLEAR, 1'b0});
         end
         CMD_BRIGHTNESS: begin
            // Park the address off screen, set the level, then put the
            // cursor address back.
            writes.push_back('{RS_INSTR, INSTR_SET_DDRAM | 8'(COLUMNS & 'h7F), 1'b0});
            writes.push_back('{RS_INSTR, INSTR_FUNCTION_SET | {6'b0, r.level}, 1'b0});
            writes.push_back('{RS_DATA, {6'b0, r.level}, 1'b0});
            ddram_addr = INSTR_SET_DDRAM | {1'b0, disp_row, disp_col};
            writes.push_back('{RS_INSTR, ddram_addr, 1'b0});
         end
         CMD_DEFINE_GLYPH: begin
            writes.push_back('{RS_INSTR, INSTR_SET_CGRAM | {2'b0, r.glyph_id, 3'b0}, 1'b0});
            for (int i = 0; i < 8; i++) begin
               writes.push_back('{RS_DATA, r.glyph_rows[8*i +: 8], 1'b0});
            end
            glyphs_defined++;
         end
         CMD_PRINT_BEGIN: begin
            ddram_addr = INSTR_SET_DDRAM | {1'b0, disp_row, disp_col};
            writes.push_back('{RS_INSTR, ddram_addr, 1'b0});
         end
         default: begin
         end
      endcase
      if (writes.size() > 0) begin
         writes[writes.size() - 1].last = 1'b1;
      end
   endfunction

   // Builds one directed row. A pin_byte of -1 leaves the row to the
   // predictor; any other value is the single instruction write expected.
   function automatic request_plan_t step_row(input logic [2:0] cmd, input logic [7:0] ch,
                                              input logic [7:0] c, input logic [7:0] r,
                                              input logic [1:0] lvl, input logic [2:0] gid,
                                              input logic [63:0] glyph, input int pin_byte);
      request_plan_t p;
      p.req = '{cmd, ch, c, r, lvl, gid, glyph};
      p.pinned = (pin_byte >= 0);
      p.typed_write = '{RS_INSTR, 8'(pin_byte), 1'b1};
      return p;
   endfunction

   // Every field random, so the bits that a request ignores toggle too.
   function automatic lcdseq_req_type random_request(input logic [2:0] cmd);
      lcdseq_req_type r;
      r.cmd        = cmd;
      r.char_code  = 8'($urandom);
      r.col        = 8'($urandom);
      r.row        = 8'($urandom);
      r.level      = 2'($urandom);
      r.glyph_id   = 3'($urandom);
      r.glyph_rows = {$urandom(), $urandom()};
      return r;
   endfunction

   // Drives one request from a falling edge and holds it until it is taken.
   // Between bursts the sender drops push for a random gap; a gap of zero
   // keeps push high so back-to-back requests are exercised too.
   task automatic send_request(input request_plan_t plan);
      int gap;
      pending_plans.push_back(plan);
      req_data = plan.req;
      req_push = 1'b1;
      do begin
         @(posedge clock);
      end while (req_full);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_push = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150)
                                                  : $urandom_range(1, 16);
      end
   endtask

   // The receiver changes its stall habit every so often: pop on every cycle,
   // pop at random, follow a rotating bit mask, or pop only now and then.
   always @(negedge clock) begin : result_drain
      int         stall_mode;
      int         mode_left;
      int         tick;
      logic [7:0] pop_mask;
      if (mode_left <= 0) begin
         stall_mode = $urandom_range(0, 3);
         mode_left  = $urandom_range(30, 200);
         pop_mask   = 8'($urandom_range(1, 255));
      end
      mode_left--;
      tick++;
      if (draining) begin
         rsp_pop <= 1'b1;
      end else begin
         case (stall_mode)
            0: rsp_pop <= 1'b1;
            1: rsp_pop <= 1'($urandom);
            2: rsp_pop <= pop_mask[tick % 8];
            default: rsp_pop <= (tick % 6 == 0);
         endcase
      end
   end

   // Observes both handshakes at the rising edge. A request taken in this
   // cycle is forecast before any write is checked, so the order of the two
   // within the edge never matters.
   always @(posedge clock) begin : bus_monitor
      request_plan_t  plan;
      lcdseq_rsp_type fresh[$];
      lcdseq_rsp_type want;
      bit             progressed;
      if (reset) begin
         disp_col    = '0;
         disp_row    = 1'b0;
         idle_cycles = 0;
      end else begin
         progressed = 1'b0;
         if (req_push && !req_full) begin
            plan = pending_plans.pop_front();
            forecast_bus_writes(req_data, fresh);
            if (plan.pinned) begin
               fresh.delete();
               fresh.push_back(plan.typed_write);
            end
            foreach (fresh[i]) expected_writes.push_back(fresh[i]);
            if (req_data.cmd == CMD_UNUSED) ignored_taken++;
            else requests_taken++;
            progressed = 1'b1;
         end
         if (rsp_pop && !rsp_empty) begin
            progressed = 1'b1;
            writes_checked++;
            if (expected_writes.size() == 0) begin
               write_mismatches++;
               if (write_mismatches <= 10) begin
                  $display("Unexpected bus write: rs=%0b byte=%02h last=%0b",
                           rsp_data.reg_select, rsp_data.bus_byte, rsp_data.last);
               end
            end else begin
               want = expected_writes.pop_front();
               if (rsp_data.reg_select !== want.reg_select ||
                   rsp_data.bus_byte !== want.bus_byte ||
                   rsp_data.last !== want.last) begin
                  write_mismatches++;
                  if (write_mismatches <= 10) begin
                     $display("Bus write %0d wrong: expected rs=%0b byte=%02h last=%0b, %s",
                              writes_checked, want.reg_select, want.bus_byte, want.last,
                              $sformatf("got rs=%0b byte=%02h last=%0b",
                                        rsp_data.reg_select, rsp_data.bus_byte,
                                        rsp_data.last));
                  end
               end
            end
         end
         // Watchdog: a long stretch with neither side moving means a hang.
         if (progressed) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("Timeout: no request or bus write moved for %0d cycles", IDLE_LIMIT);
               $display("FAILED: results differ");
               $finish;
            end
         end
      end
   end

   initial begin : stimulus
      lcdseq_req_type r;
      request_plan_t  plan;
      int             taken_random;
      int             pick;
      int             run;
      reset    = 1'b1;
      req_push = 1'b0;
      req_data = '0;

      // Directed rows. Single instruction writes whose value is plain from
      // the cursor position are typed in; the rest go to the predictor.
      // Right after reset the cursor sits at the top left corner.
      directed_rows.push_back(step_row(CMD_PRINT_BEGIN, 8'h00, 8'h00, 8'h00, 2'd0, 3'd0,
                                       64'h0, 'h80));
      directed_rows.push_back(step_row(CMD_CLEAR, 8'h00, 8'h00, 8'h00, 2'd0, 3'd0,
                                       64'h0, 'h01));
      directed_rows.push_back(step_row(CMD_INIT, 8'hFF, 8'hFF, 8'hFF, 2'd3, 3'd7,
                                       '1, -1));
      // An unused code with every field at its top must produce nothing.
      directed_rows.push_back(step_row(CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, 2'd3, 3'd7,
                                       '1, -1));
      // Both coordinates at their maximum fold to the last column of row 1.
      directed_rows.push_back(step_row(CMD_SET_CURSOR, 8'h00, 8'hFF, 8'hFF, 2'd0, 3'd0,
                                       64'h0, 'hCF));
      // A character in the very last cell wraps back to the top row.
      directed_rows.push_back(step_row(CMD_PUT_CHAR, 8'hFF, 8'h00, 8'h00, 2'd0, 3'd0,
                                       64'h0, -1));
      directed_rows.push_back(step_row(CMD_SET_CURSOR, 8'h00, 8'h00, 8'h00, 2'd0, 3'd0,
                                       64'h0, 'h80));
      directed_rows.push_back(step_row(CMD_PUT_CHAR, 8'h00, 8'hFF, 8'hFF, 2'd3, 3'd7,
                                       '1, -1));
      directed_rows.push_back(step_row(CMD_SET_CURSOR, 8'h00, 8'd15, 8'd0, 2'd0, 3'd0,
                                       64'h0, 'h8F));
      // From the end of the top row a character moves the cursor down.
      directed_rows.push_back(step_row(CMD_PUT_CHAR, 8'h41, 8'h00, 8'h00, 2'd0, 3'd0,
                                       64'h0, -1));
      directed_rows.push_back(step_row(CMD_PRINT_BEGIN, 8'h00, 8'h00, 8'h00, 2'd0, 3'd0,
                                       64'h0, 'hC0));
      directed_rows.push_back(step_row(CMD_BRIGHTNESS, 8'h00, 8'h00, 8'h00, 2'd0, 3'd0,
                                       64'h0, -1));
      directed_rows.push_back(step_row(CMD_BRIGHTNESS, 8'h00, 8'h00, 8'h00, 2'd3, 3'd0,
                                       64'h0, -1));
      directed_rows.push_back(step_row(CMD_DEFINE_GLYPH, 8'h00, 8'h00, 8'h00, 2'd0, 3'd0,
                                       64'h0, -1));
      directed_rows.push_back(step_row(CMD_DEFINE_GLYPH, 8'h00, 8'h00, 8'h00, 2'd0, 3'd7,
                                       '1, -1));
      directed_rows.push_back(step_row(CMD_DEFINE_GLYPH, 8'h5A, 8'h00, 8'h00, 2'd1, 3'd5,
                                       64'h0123_4567_89AB_CDEF, -1));
      // Coordinates one past the display size fold back to zero.
      directed_rows.push_back(step_row(CMD_SET_CURSOR, 8'h00, 8'd16, 8'd2, 2'd0, 3'd0,
                                       64'h0, 'h80));
      directed_rows.push_back(step_row(CMD_SET_CURSOR, 8'h00, 8'd31, 8'd1, 2'd0, 3'd0,
                                       64'h0, 'hCF));
      directed_rows.push_back(step_row(CMD_UNUSED, 8'h00, 8'h00, 8'h00, 2'd0, 3'd0,
                                       64'h0, -1));
      directed_rows.push_back(step_row(CMD_PUT_CHAR, 8'h80, 8'h00, 8'h00, 2'd0, 3'd0,
                                       64'h0, -1));
      // Fields a request does not use must not change its writes.
      directed_rows.push_back(step_row(CMD_CLEAR, 8'hA5, 8'h3C, 8'hC3, 2'd2, 3'd6,
                                       64'hFEDC_BA98_7654_3210, 'h01));
      directed_rows.push_back(step_row(CMD_INIT, 8'h00, 8'h00, 8'h00, 2'd0, 3'd0,
                                       64'h0, -1));
      directed_rows.push_back(step_row(CMD_PRINT_BEGIN, 8'hFF, 8'hFF, 8'hFF, 2'd3, 3'd7,
                                       '1, 'h80));

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i]) send_request(directed_rows[i]);

      // Random part. A third of the time it writes a line of text: place the
      // cursor, then a run of characters that is often long enough to wrap
      // one or more rows. Otherwise it sends a single request of any kind.
      plan.pinned = 1'b0;
      plan.typed_write = '0;
      taken_random = 0;
      while (taken_random < RANDOM_REQUESTS) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            plan.req = random_request($urandom_range(0, 1) ? CMD_SET_CURSOR
                                                           : CMD_PRINT_BEGIN);
            send_request(plan);
            run = $urandom_range(1, 40);
            repeat (run) begin
               plan.req = random_request(CMD_PUT_CHAR);
               send_request(plan);
            end
            taken_random += run + 1;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 30)      r = random_request(CMD_PUT_CHAR);
            else if (pick < 45) r = random_request(CMD_SET_CURSOR);
            else if (pick < 53) r = random_request(CMD_PRINT_BEGIN);
            else if (pick < 61) r = random_request(CMD_CLEAR);
            else if (pick < 71) r = random_request(CMD_BRIGHTNESS);
            else if (pick < 81) r = random_request(CMD_DEFINE_GLYPH);
            else if (pick < 90) r = random_request(CMD_INIT);
            else                r = random_request(CMD_UNUSED);
            plan.req = r;
            send_request(plan);
            if (r.cmd != CMD_UNUSED) taken_random++;
         end
      end

      // Stop sending, let the receiver pop freely and collect what is owed.
      req_push = 1'b0;
      draining = 1'b1;
      while (expected_writes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d requests and %0d dropped unused codes, %0d bus writes.",
               requests_taken, ignored_taken, writes_checked);
      $display("Cursor wrapped %0d times, %0d glyphs defined, %0d write mismatches.",
               cursor_wraps, glyphs_defined, write_mismatches);
      if (write_mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
